// ----- sv/scale_space_extremum_detect_core_macros.svh -----
// Assertion macros shared by the extremum detector RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SCALE_SPACE_EXTREMUM_DETECT_CORE_MACROS_SVH
`define SCALE_SPACE_EXTREMUM_DETECT_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSED_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ssed_pkg.sv -----
// Shared constants and types of the scale-space extremum detector.
// Depends on nothing; imported by ssed_window and the core module.
`timescale 1ns / 1ps
package ssed_pkg;

	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FW_BITS         = 11;
	localparam int ROW_BITS        = 12;
	localparam int NUM_LAYERS      = 3;

	localparam logic [FW_BITS-1:0]  FRAME_WIDTH_RST  = 11'd640;
	localparam logic [ROW_BITS-1:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [ROW_BITS-1:0] MIN_DIM          = 12'd3;

	// Configuration register indexes.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Control handed from the line-buffer stage to the window.
	typedef struct packed {
		logic                shift;
		logic                check;
		logic [ROW_BITS-1:0] row;
	} win_ctl_t;

	// Decision handed back from the window.
	typedef struct packed {
		logic                hit;
		logic                is_max;
		logic [ROW_BITS-1:0] row;
	} win_res_t;

endpackage

// ----- sv/ssed_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module ssed_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, and read port returning old data on a collision.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/ssed_window.sv -----
// 3x3x3 sample window with the 26-neighbor comparison.
// Depends on ssed_pkg.
`timescale 1ns / 1ps
module ssed_window
	import ssed_pkg::*;
#(
	parameter int SB = SAMPLE_BITS_DEF,
	parameter int CW = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  win_ctl_t             ctl,
	input  logic [CW-1:0]        col_in,
	input  logic signed [SB-1:0] new_top [NUM_LAYERS],
	input  logic signed [SB-1:0] new_ctr [NUM_LAYERS],
	input  logic signed [SB-1:0] new_bot [NUM_LAYERS],
	output win_res_t             res,
	output logic [CW-1:0]        col_out
);

	logic signed [SB-1:0] win_q [NUM_LAYERS][3][3];
	logic                 check_s2;
	logic [ROW_BITS-1:0]  row_s2;
	logic [CW-1:0]        col_s2;
	logic                 all_low;
	logic                 none_low;

	// Shift each layer one column left and load the new column.
	always_ff @(posedge clk) begin
		if (en && ctl.shift) begin
			for (int l = 0; l < NUM_LAYERS; l++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[l][r][0] <= win_q[l][r][1];
					win_q[l][r][1] <= win_q[l][r][2];
				end
				win_q[l][0][2] <= new_top[l];
				win_q[l][1][2] <= new_ctr[l];
				win_q[l][2][2] <= new_bot[l];
			end
		end
	end

	// Position of the centre under test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_s2 <= 1'b0;
		end else if (en) begin
			check_s2 <= ctl.shift && ctl.check;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2 <= ctl.row;
			col_s2 <= col_in;
		end
	end

	// Compare every neighbor against the middle-layer centre.
	always_comb begin
		all_low  = 1'b1;
		none_low = 1'b1;
		for (int l = 0; l < NUM_LAYERS; l++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (!(l == 1 && r == 1 && c == 1)) begin
						if (win_q[l][r][c] < win_q[1][1][1]) begin
							none_low = 1'b0;
						end else begin
							all_low = 1'b0;
						end
					end
				end
			end
		end
	end

	assign res.hit    = check_s2 && (all_low || none_low);
	assign res.is_max = all_low;
	assign res.row    = row_s2;
	assign col_out    = col_s2;

endmodule

// ----- sv/scale_space_extremum_detect_core.sv -----
// Pipeline: an accepted pixel passes stage 1 (line RAM read), the window shift
// and the compare, its report then standing in the output register.
// Throughput: one pixel per cycle unless stalled; a beat reads both line RAMs
// and writes one. Stalls: the input stalls only while a report waits on a
// stalled output. Reset: arst_n clears counters, valid flags and configuration
// registers to defaults; line RAM and window data stay undefined until written.
`timescale 1ns / 1ps
`include "scale_space_extremum_detect_core_macros.svh"
module scale_space_extremum_detect_core
	import ssed_pkg::*;
#(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          frame_start,
	input  logic signed [SAMPLE_BITS-1:0] value_front,
	input  logic signed [SAMPLE_BITS-1:0] value_mid,
	input  logic signed [SAMPLE_BITS-1:0] value_back,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          is_maximum,
	output logic [ROW_BITS-1:0]           row,
	output logic [$clog2(MAX_WIDTH)-1:0]  col,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [ROW_BITS-1:0]           cfg_data
);

	localparam int SB  = SAMPLE_BITS;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WEB = (CW + 1 > FW_BITS) ? CW + 1 : FW_BITS;
	localparam int EW  = NUM_LAYERS * SB;

	logic [FW_BITS-1:0]  fw_q;
	logic [ROW_BITS-1:0] fh_q;
	logic [CW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;

	logic                en;
	logic                acc;
	logic [WEB-1:0]      w_eff;
	logic [ROW_BITS-1:0] h_eff;
	logic [CW-1:0]       c_cur;
	logic [ROW_BITS-1:0] r_cur;
	logic [WEB-1:0]      c_inc;
	logic [ROW_BITS-1:0] r_inc;

	logic                 valid_s1;
	logic                 check_s1;
	logic                 par_s1;
	logic [ROW_BITS-1:0]  row_s1;
	logic [CW-1:0]        col_s1;
	logic [CW-1:0]        addr_s1;
	logic signed [SB-1:0] v_s1 [NUM_LAYERS];

	logic [EW-1:0] rdata_even;
	logic [EW-1:0] rdata_odd;
	logic [EW-1:0] ent_even;
	logic [EW-1:0] ent_odd;
	logic [EW-1:0] prev1;
	logic [EW-1:0] prev2;
	logic [EW-1:0] wdata;
	logic          we;
	logic          we_even;
	logic          we_odd;
	logic          fwd_hit;
	logic          fwd_valid_q;
	logic          fwd_par_q;
	logic [CW-1:0] fwd_addr_q;
	logic [EW-1:0] fwd_data_q;

	logic signed [SB-1:0] new_top [NUM_LAYERS];
	logic signed [SB-1:0] new_ctr [NUM_LAYERS];
	logic signed [SB-1:0] new_bot [NUM_LAYERS];
	win_ctl_t             wctl;
	win_res_t             wres;
	logic [CW-1:0]        wcol;

	// The pipeline moves unless a report waits on a stalled output.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign acc      = in_valid && en;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_WIDTH_RST;
			fh_q <= FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  fw_q <= cfg_data[FW_BITS-1:0];
				REG_FRAME_HEIGHT: fh_q <= cfg_data;
				default:          fw_q <= fw_q;
			endcase
		end
	end

	// Clamp frame size and resolve the position of the incoming pixel.
	always_comb begin
		w_eff = WEB'(fw_q);
		if (w_eff < WEB'(3)) begin
			w_eff = WEB'(3);
		end else if (w_eff > WEB'(MAX_WIDTH)) begin
			w_eff = WEB'(MAX_WIDTH);
		end
		h_eff = (fh_q < MIN_DIM) ? MIN_DIM : fh_q;
		c_cur = frame_start ? '0 : col_q;
		r_cur = frame_start ? '0 : row_q;
		if (WEB'(c_cur) >= w_eff) begin
			c_cur = '0;
		end
		if (r_cur >= h_eff) begin
			r_cur = '0;
		end
		c_inc = WEB'(c_cur) + WEB'(1);
		r_inc = r_cur + 12'd1;
	end

	// Position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (c_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (r_inc >= h_eff) ? '0 : r_inc;
			end else begin
				col_q <= c_inc[CW-1:0];
				row_q <= r_cur;
			end
		end
	end

	// Stage 1 registers, alongside the line RAM read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			check_s1 <= (r_cur >= 12'd2) && (WEB'(c_cur) >= WEB'(2));
			par_s1   <= r_cur[0];
			row_s1   <= r_cur - 12'd1;
			col_s1   <= c_cur - CW'(1);
			addr_s1  <= c_cur;
			v_s1[0]  <= value_front;
			v_s1[1]  <= value_mid;
			v_s1[2]  <= value_back;
		end
	end

	// One line RAM per row parity; each entry holds one column of all three layers.
	ssed_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_WIDTH)
	) u_line_even (
		.clk  (clk),
		.we   (we_even),
		.waddr(addr_s1),
		.wdata(wdata),
		.re   (acc),
		.raddr(c_cur),
		.rdata(rdata_even)
	);

	ssed_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_WIDTH)
	) u_line_odd (
		.clk  (clk),
		.we   (we_odd),
		.waddr(addr_s1),
		.wdata(wdata),
		.re   (acc),
		.raddr(c_cur),
		.rdata(rdata_odd)
	);

	// Forward the last write when the next beat reads the same column.
	assign fwd_hit  = fwd_valid_q && (fwd_addr_q == addr_s1);
	assign ent_even = (fwd_hit && !fwd_par_q) ? fwd_data_q : rdata_even;
	assign ent_odd  = (fwd_hit && fwd_par_q) ? fwd_data_q : rdata_odd;

	// The older line shares the parity of the current row and is overwritten by it.
	assign prev2   = par_s1 ? ent_odd : ent_even;
	assign prev1   = par_s1 ? ent_even : ent_odd;
	assign we      = en && valid_s1;
	assign we_even = we && !par_s1;
	assign we_odd  = we && par_s1;

	always_comb begin
		for (int l = 0; l < NUM_LAYERS; l++) begin
			new_top[l]        = prev2[l*SB +: SB];
			new_ctr[l]        = prev1[l*SB +: SB];
			new_bot[l]        = v_s1[l];
			wdata[l*SB +: SB] = v_s1[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fwd_par_q  <= par_s1;
			fwd_addr_q <= addr_s1;
			fwd_data_q <= wdata;
		end
	end

	// Window and compare.
	assign wctl.shift = valid_s1;
	assign wctl.check = check_s1;
	assign wctl.row   = row_s1;

	ssed_window #(
		.SB(SB),
		.CW(CW)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl    (wctl),
		.col_in (col_s1),
		.new_top(new_top),
		.new_ctr(new_ctr),
		.new_bot(new_bot),
		.res    (wres),
		.col_out(wcol)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= wres.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			is_maximum <= wres.is_max;
			row        <= wres.row;
			col        <= wcol;
		end
	end

	`SSED_ASSERT_NOW(a_report_interior, clk, arst_n, out_valid, (row != '0) && (col != '0), "report on the frame border")
	`SSED_ASSERT_NOW(a_col_in_range, clk, arst_n, 1'b1, WEB'(col_q) < WEB'(MAX_WIDTH), "column counter out of range")
	`SSED_ASSERT_NEXT(a_col_moves, clk, arst_n, acc && !frame_start, col_q != $past(col_q), "column counter did not advance")

endmodule
